// ===== sv/pixel_plot_rotate_flip_assert.svh =====
// Assertion macros for the pixel plot block.
`ifndef PIXEL_PLOT_ROTATE_FLIP_ASSERT_SVH
`define PIXEL_PLOT_ROTATE_FLIP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define PPRF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define PPRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPRF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/pprf_pkg.sv =====
// Shared types and constants for the pixel plot block.
package pprf_pkg;

  localparam int PanelWidth  = 200;
  localparam int PanelHeight = 200;
  localparam int BufferBytes = 8192;
  localparam logic WhiteMask = 1'b1;

  localparam int BufAw  = $clog2(BufferBytes);
  localparam int AddrW  = 13;
  localparam int CoordW = 16;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 3;
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [CoordW-1:0] PanelWm1 = CoordW'(PanelWidth - 1);
  localparam logic [CoordW-1:0] PanelHm1 = CoordW'(PanelHeight - 1);

  typedef enum logic {
    OP_PLOT = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROTATION      = 3'd0,
    REG_FLIP_MODE     = 3'd1,
    REG_MIRROR_WIDTH  = 3'd2,
    REG_MIRROR_HEIGHT = 3'd3,
    REG_WINDOW_LEFT   = 3'd4,
    REG_WINDOW_RIGHT  = 3'd5,
    REG_ROW_FIRST     = 3'd6,
    REG_ROW_LAST      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] rotation;
    logic [1:0] flip_mode;
    logic [7:0] mirror_width;
    logic [7:0] mirror_height;
    logic [7:0] window_left;
    logic [7:0] window_right;
    logic [7:0] row_first;
    logic [7:0] row_last;
  } cfg_t;

  // One classified operation handed from front to back.
  typedef struct packed {
    op_e              op;
    logic             ok;       // plot survived clip and fits, or read address valid
    logic [AddrW-1:0] addr;
    logic             color;
    logic [2:0]       bit_idx;
  } item_t;

endpackage

// ===== sv/pprf_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pprf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pprf_queue.sv =====
// Short FIFO between front and back.
module pprf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pprf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pprf_pkg::item_t item_o
);
  import pprf_pkg::*;

`include "pixel_plot_rotate_flip_assert.svh"

  item_t          mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAw:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAw + 1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + QAw'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + QAw'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QAw + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QAw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `PPRF_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `PPRF_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o), "pop from empty queue")
  `PPRF_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= (QAw + 1)'(QDepth), "queue count overrun")

endmodule

// ===== sv/pprf_front.sv =====
// Front end: rotate, flip, clip and address each item.
module pprf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pprf_pkg::cfg_t                cfg_i,
  input  logic                          busy_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic                          op_i,
  input  logic [pprf_pkg::CoordW-1:0]   pixel_x_i,
  input  logic [pprf_pkg::CoordW-1:0]   pixel_y_i,
  input  logic                          pixel_color_i,
  input  logic [pprf_pkg::AddrW-1:0]    read_address_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output pprf_pkg::item_t               item_o
);
  import pprf_pkg::*;

  // Stage A: rotated and flipped panel coordinates.
  logic              a_vld_q;
  op_e               a_op_q;
  logic [CoordW-1:0] a_px_q, a_py_q;
  logic              a_color_q;
  logic [AddrW-1:0]  a_raddr_q;

  logic [CoordW-1:0] rx, ry, fx, fy, dw_m1, dh_m1;
  logic              landscape, flip_x, flip_y;

  always_comb begin
    case (cfg_i.rotation)
      ROT_0: begin
        rx = pixel_x_i;
        ry = pixel_y_i;
      end
      ROT_90: begin
        rx = PanelWm1 - pixel_y_i;
        ry = pixel_x_i;
      end
      ROT_180: begin
        rx = PanelWm1 - pixel_x_i;
        ry = PanelHm1 - pixel_y_i;
      end
      default: begin
        rx = pixel_y_i;
        ry = PanelHm1 - pixel_x_i;
      end
    endcase
  end

  // Flip axes swap in landscape.
  assign landscape = cfg_i.rotation[0];
  assign flip_x    = landscape ? cfg_i.flip_mode[1] : cfg_i.flip_mode[0];
  assign flip_y    = landscape ? cfg_i.flip_mode[0] : cfg_i.flip_mode[1];
  assign dw_m1     = {8'b0, cfg_i.mirror_width} - CoordW'(1);
  assign dh_m1     = {8'b0, cfg_i.mirror_height} - CoordW'(1);
  assign fx        = flip_x ? dw_m1 - rx : rx;
  assign fy        = flip_y ? dh_m1 - ry : ry;

  assign push_o    = a_vld_q && !q_full_i;
  assign s_ready_o = !busy_i && (!a_vld_q || !q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (s_ready_o) begin
      a_vld_q <= s_valid_i;
    end else if (push_o) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      a_op_q    <= op_e'(op_i);
      a_px_q    <= fx;
      a_py_q    <= fy;
      a_color_q <= pixel_color_i;
      a_raddr_q <= read_address_i;
    end
  end

  // Stage B: clip and byte address, straight into the queue.
  logic       in_x, in_y;
  logic [8:0] row_span;
  logic [5:0] row_bytes;
  logic [7:0] dx, dy;
  logic [13:0] prod, plot_addr;

  assign in_x = ($signed(a_px_q) >= $signed({8'b0, cfg_i.window_left})) &&
                ($signed(a_px_q) <= $signed({8'b0, cfg_i.window_right}));
  assign in_y = ($signed(a_py_q) >= $signed({8'b0, cfg_i.row_first})) &&
                ($signed(a_py_q) <= $signed({8'b0, cfg_i.row_last}));

  assign row_span  = {1'b0, cfg_i.window_right} - {1'b0, cfg_i.window_left} + 9'd1;
  assign row_bytes = row_span[8:3];
  assign dx        = a_px_q[7:0] - cfg_i.window_left;
  assign dy        = a_py_q[7:0] - cfg_i.row_first;
  assign prod      = {6'b0, dy} * {8'b0, row_bytes};
  assign plot_addr = prod + {9'b0, dx[7:3]};

  always_comb begin
    item_o.op      = a_op_q;
    item_o.color   = a_color_q;
    item_o.bit_idx = ~a_px_q[2:0];
    if (a_op_q == OP_READ) begin
      item_o.addr = a_raddr_q;
      item_o.ok   = ({1'b0, a_raddr_q} < 14'(BufferBytes));
    end else begin
      item_o.addr = plot_addr[AddrW-1:0];
      item_o.ok   = in_x && in_y && (plot_addr < 14'(BufferBytes));
    end
  end

endmodule

// ===== sv/pprf_back.sv =====
// Back end: clearing pass, byte read-modify-write and result register.
module pprf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       busy_o,
  input  logic                       q_empty_i,
  input  pprf_pkg::item_t            q_item_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic                       in_page_o,
  output logic [pprf_pkg::AddrW-1:0] byte_address_o,
  output logic [7:0]                 byte_value_o
);
  import pprf_pkg::*;

`include "pixel_plot_rotate_flip_assert.svh"

  logic             clr_q;
  logic [BufAw-1:0] clr_cnt_q;

  logic             w_vld_q;
  item_t            w_item_q;

  logic             fwd_vld_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic [7:0]       fwd_data_q;

  logic             out_vld_q;
  logic             out_in_page_q;
  logic [AddrW-1:0] out_addr_q;
  logic [7:0]       out_value_q;

  logic             adv, item_we;
  logic [7:0]       ram_rdata, old_byte, new_byte, mask;
  logic             ram_we;
  logic [BufAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;

  // Whole back end moves together when the output register can take a result.
  assign adv    = !clr_q && (!out_vld_q || m_ready_i);
  assign pop_o  = adv && !q_empty_i;
  assign busy_o = clr_q;

  // Last write lands on the edge this item's read was issued: forward it.
  assign old_byte = (fwd_vld_q && (fwd_addr_q == w_item_q.addr)) ? fwd_data_q : ram_rdata;
  assign mask     = 8'(1) << w_item_q.bit_idx;
  assign new_byte = (old_byte & ~mask) | ((w_item_q.color & WhiteMask) ? mask : 8'h00);
  assign item_we  = adv && w_vld_q && (w_item_q.op == OP_PLOT) && w_item_q.ok;

  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = item_we;
      ram_waddr = w_item_q.addr[BufAw-1:0];
      ram_wdata = new_byte;
    end
  end

  pprf_ram #(
    .Width(8),
    .Depth(BufferBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (q_item_i.addr[BufAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      w_vld_q   <= 1'b0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_cnt_q == BufAw'(BufferBytes - 1)) begin
          clr_q     <= 1'b0;
          clr_cnt_q <= '0;
        end else begin
          clr_cnt_q <= clr_cnt_q + BufAw'(1);
        end
      end
      if (adv) begin
        w_vld_q   <= !q_empty_i;
        fwd_vld_q <= item_we;
        out_vld_q <= w_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      w_item_q <= q_item_i;
    end
    if (adv) begin
      fwd_addr_q <= w_item_q.addr;
      fwd_data_q <= new_byte;
    end
    if (adv && w_vld_q) begin
      if (w_item_q.op == OP_READ) begin
        out_in_page_q <= w_item_q.ok;
        out_addr_q    <= w_item_q.addr;
        out_value_q   <= w_item_q.ok ? old_byte : 8'h00;
      end else if (w_item_q.ok) begin
        out_in_page_q <= 1'b1;
        out_addr_q    <= w_item_q.addr;
        out_value_q   <= new_byte;
      end else begin
        out_in_page_q <= 1'b0;
        out_addr_q    <= '0;
        out_value_q   <= 8'h00;
      end
    end
  end

  assign m_valid_o      = out_vld_q;
  assign in_page_o      = out_in_page_q;
  assign byte_address_o = out_addr_q;
  assign byte_value_o   = out_value_q;

  `PPRF_ASSERT(a_no_pop_in_clear, clk_i, rst_ni, clr_q |-> !pop_o, "pop during clearing pass")
  `PPRF_ASSERT(a_w_hold, clk_i, rst_ni, (w_vld_q && !adv) |=> (w_vld_q && $stable(w_item_q)), "stalled item lost")
  `PPRF_ASSERT(a_clr_done, clk_i, rst_ni, $fell(clr_q) |-> (clr_cnt_q == '0), "clear count not rewound")
  `PPRF_ASSERT(a_no_out_in_clear, clk_i, rst_ni, clr_q |-> !out_vld_q, "result during clearing pass")

endmodule

// ===== sv/pixel_plot_rotate_flip.sv =====
// Top level of the rotating, flipping one-bit pixel writer and page buffer.
//
//  Port group   Dir  Payload (low bit first)                       Transfer when
//  s_axis_*     in   tuser: operation; tdata: pixel_x, pixel_y,    tvalid && tready
//                    pixel_color, read_address, 2 zero bits
//  m_axis_*     out  tuser: in_page; tdata: byte_address,          tvalid && tready
//                    byte_value, 3 zero bits
//  cfg_*        in   index 0..7, data 8 bits                       cfg_we_i high
//
//  Sustains one transfer per cycle when the output does not stall; from input to
//  output register: transform stage, clip/address stage into the queue, buffer read.
//  The back end writes the modified byte when the item leaves the read stage; a
//  one-entry bypass covers a following item on the same byte.
//  After reset a clearing pass zeroes all 8192 bytes of the buffer, one byte per
//  cycle, with s_axis_tready low; configuration writes are taken meanwhile.
//  An output stall freezes the back end; the two-entry queue then fills and
//  s_axis_tready drops.
module pixel_plot_rotate_flip (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [pprf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pprf_pkg::CfgW-1:0]    cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata,  // pixel_x, pixel_y, pixel_color, read_address
  input  logic [0:0]                   s_axis_tuser,  // operation
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // byte_address, byte_value
  output logic [0:0]                   m_axis_tuser   // in_page
);
  import pprf_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation      <= 2'd0;
      cfg_q.flip_mode     <= 2'd0;
      cfg_q.mirror_width  <= 8'd200;
      cfg_q.mirror_height <= 8'd200;
      cfg_q.window_left   <= 8'd0;
      cfg_q.window_right  <= 8'd199;
      cfg_q.row_first     <= 8'd0;
      cfg_q.row_last      <= 8'd199;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ROTATION:      cfg_q.rotation      <= cfg_data_i[1:0];
        REG_FLIP_MODE:     cfg_q.flip_mode     <= cfg_data_i[1:0];
        REG_MIRROR_WIDTH:  cfg_q.mirror_width  <= cfg_data_i;
        REG_MIRROR_HEIGHT: cfg_q.mirror_height <= cfg_data_i;
        REG_WINDOW_LEFT:   cfg_q.window_left   <= cfg_data_i;
        REG_WINDOW_RIGHT:  cfg_q.window_right  <= cfg_data_i;
        REG_ROW_FIRST:     cfg_q.row_first     <= cfg_data_i;
        REG_ROW_LAST:      cfg_q.row_last      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  busy, q_full, q_empty, push, pop;
  item_t push_item, head_item;

  pprf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .busy_i         (busy),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .op_i           (s_axis_tuser[0]),
    .pixel_x_i      (s_axis_tdata[15:0]),
    .pixel_y_i      (s_axis_tdata[31:16]),
    .pixel_color_i  (s_axis_tdata[32]),
    .read_address_i (s_axis_tdata[45:33]),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  pprf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (head_item)
  );

  logic             in_page;
  logic [AddrW-1:0] byte_address;
  logic [7:0]       byte_value;

  pprf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .busy_o         (busy),
    .q_empty_i      (q_empty),
    .q_item_i       (head_item),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .in_page_o      (in_page),
    .byte_address_o (byte_address),
    .byte_value_o   (byte_value)
  );

  assign m_axis_tdata = {3'b000, byte_value, byte_address};
  assign m_axis_tuser = in_page;

endmodule
